// ===== rtl/m4sd_pkg.sv =====
// ----------------------------------------------------------------------------
// m4sd_pkg: shared types and constants of the four-digit display driver
// Holds the scan phase encoding, the queue entry layout, the configuration
// bundle and the decimal digit split helper.
// ----------------------------------------------------------------------------
package m4sd_pkg;

    // Largest value that the four digits can show.
    localparam logic [13:0] K_VALUE_MAX = 14'd9999;
    localparam logic [13:0] K_THOU      = 14'd1000;
    localparam logic [13:0] K_HUND      = 14'd100;
    localparam logic [13:0] K_TEN       = 14'd10;

    // Configuration register indexes.
    localparam logic [2:0] REG_DIGIT_TICKS = 3'd0;
    localparam logic [2:0] REG_NIGHT_TICKS = 3'd1;
    localparam logic [2:0] REG_PIN_MAP     = 3'd2;
    localparam logic [2:0] REG_SEG_LOW     = 3'd3;
    localparam logic [2:0] REG_SEG_HIGH    = 3'd4;

    // Configuration reset values (identity pin map, standard a-to-g table).
    localparam logic [15:0] RST_DIGIT_TICKS = 16'd5;
    localparam logic [15:0] RST_NIGHT_TICKS = 16'd10;
    localparam logic [23:0] RST_PIN_MAP     = 24'd16434824;
    localparam logic [63:0] RST_SEG_LOW     = 64'd539707747820308031;
    localparam logic [15:0] RST_SEG_HIGH    = 16'd28543;

    // Scan phases of one round, one-hot.
    typedef enum logic [4:0] {
        PH_THOU  = 5'b00001,
        PH_HUND  = 5'b00010,
        PH_TENS  = 5'b00100,
        PH_ONES  = 5'b01000,
        PH_NIGHT = 5'b10000
    } t_phase;

    // One classified transaction as it waits between front and back.
    typedef struct packed {
        logic        cmd;      // 1: show, 0: tick
        logic [3:0]  thou;
        logic [3:0]  hund;
        logic [3:0]  tens;
        logic [3:0]  ones;
        logic        night;
        logic [15:0] rounds;
        t_phase      first;    // first digit phase after leading zeros
    } t_qent;

    // Configuration registers as seen by the scan engine.
    typedef struct packed {
        logic [15:0] digit_ticks;
        logic [15:0] night_ticks;
        logic [23:0] pin_map;
        logic [63:0] seg_low;
        logic [15:0] seg_high;
    } t_cfg;

    // Quotient digit and remainder of one decimal split step.
    typedef struct packed {
        logic [3:0]  q;
        logic [13:0] r;
    } t_split;

    // Split off one decimal digit of weight unit; v must stay below 10*unit.
    // The compares are independent and resolve to constants per call site.
    function automatic t_split split_dec(input logic [13:0] v, input logic [13:0] unit);
        t_split res;
        res.q = 4'd0;
        res.r = v;
        for (int k = 1; k < 10; k++) begin
            if (v >= 14'(k * int'(unit))) begin
                res.q = 4'(k);
                res.r = v - 14'(k * int'(unit));
            end
        end
        return res;
    endfunction

endpackage

// ===== rtl/multiplexed_4digit_7seg_driver.sv =====
// ----------------------------------------------------------------------------
// multiplexed_4digit_7seg_driver: four-digit multiplexed display driver
// Show transactions load a value and a round count, tick transactions step
// the digit scan; every transaction returns the display drive it leaves.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  s         in         i_s_tvalid/o_s_tready  tdata: value, night, rounds
//                                              tuser: cmd
//  m         out        o_m_tvalid/i_m_tready  tdata: segments, digit_enable_n,
//                                              active
//  cfg       in         i_cfg_valid/o_cfg_ready index, 64-bit data
//
//  One transaction per cycle sustained while the output is not stalled; a
//  taken transaction passes three input stages, one queue slot and one output
//  register before its result appears, and the scan engine updates once per transaction.
//  Reset is synchronous and active low; it clears the scan to idle and loads
//  the default phase lengths, pin map and segment table.
//  A stalled output holds its result; the queue absorbs input until it fills.
// ----------------------------------------------------------------------------
module multiplexed_4digit_7seg_driver #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,    // [13:0] value, [14] night, [30:15] rounds
    input  logic        i_s_tuser,    // [0] cmd
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,    // [7:0] segments, [11:8] digit_enable_n, [12] active
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    m4sd_pkg::t_cfg  r_cfg;
    m4sd_pkg::t_qent fq_entry, qb_entry;
    logic            fq_valid, fq_ready;
    logic            qb_valid, qb_pop;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.digit_ticks <= m4sd_pkg::RST_DIGIT_TICKS;
            r_cfg.night_ticks <= m4sd_pkg::RST_NIGHT_TICKS;
            r_cfg.pin_map     <= m4sd_pkg::RST_PIN_MAP;
            r_cfg.seg_low     <= m4sd_pkg::RST_SEG_LOW;
            r_cfg.seg_high    <= m4sd_pkg::RST_SEG_HIGH;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                m4sd_pkg::REG_DIGIT_TICKS: r_cfg.digit_ticks <= i_cfg_data[15:0];
                m4sd_pkg::REG_NIGHT_TICKS: r_cfg.night_ticks <= i_cfg_data[15:0];
                m4sd_pkg::REG_PIN_MAP:     r_cfg.pin_map     <= i_cfg_data[23:0];
                m4sd_pkg::REG_SEG_LOW:     r_cfg.seg_low     <= i_cfg_data;
                m4sd_pkg::REG_SEG_HIGH:    r_cfg.seg_high    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    m4sd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_q_valid  (fq_valid),
        .i_q_ready  (fq_ready),
        .o_q_entry  (fq_entry)
    );

    m4sd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fq_valid),
        .o_push_ready (fq_ready),
        .i_push_entry (fq_entry),
        .o_pop_valid  (qb_valid),
        .i_pop        (qb_pop),
        .o_pop_entry  (qb_entry)
    );

    m4sd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_valid  (qb_valid),
        .o_q_pop    (qb_pop),
        .i_q_entry  (qb_entry),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

// ===== rtl/m4sd_front.sv =====
// ----------------------------------------------------------------------------
// m4sd_front: input stage of the display driver
// Accepts transactions, clamps the value and splits it into four decimal
// digits over three pipeline stages, then hands classified entries on.
// ----------------------------------------------------------------------------
module m4sd_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [31:0]          i_s_tdata,   // [13:0] value, [14] night, [30:15] rounds
    input  logic                 i_s_tuser,   // [0] cmd
    output logic                 o_q_valid,
    input  logic                 i_q_ready,
    output m4sd_pkg::t_qent      o_q_entry
);

    // Stage valid bits and load enables (a stage loads when it can move on).
    logic r_v1, r_v2, r_v3;
    logic ld1, ld2, ld3;

    // Stage 1: clamped value.
    logic        r_cmd1, r_night1;
    logic [13:0] r_val1;
    logic [15:0] r_rounds1;

    // Stage 2: thousands split off.
    logic        r_cmd2, r_night2;
    logic [3:0]  r_thou2;
    logic [9:0]  r_rem2;
    logic [15:0] r_rounds2;

    // Stage 3: hundreds split off.
    logic        r_cmd3, r_night3;
    logic [3:0]  r_thou3, r_hund3;
    logic [6:0]  r_rem3;
    logic [15:0] r_rounds3;

    logic [13:0]      in_value, clamped;
    m4sd_pkg::t_split sp_thou, sp_hund, sp_tens;

    assign ld3        = !r_v3 || i_q_ready;
    assign ld2        = !r_v2 || ld3;
    assign ld1        = !r_v1 || ld2;
    assign o_s_tready = ld1;

    // Clamp values above the four-digit range.
    assign in_value = i_s_tdata[13:0];
    assign clamped  = (in_value > m4sd_pkg::K_VALUE_MAX) ? m4sd_pkg::K_VALUE_MAX : in_value;

    assign sp_thou = m4sd_pkg::split_dec(r_val1, m4sd_pkg::K_THOU);
    assign sp_hund = m4sd_pkg::split_dec({4'd0, r_rem2}, m4sd_pkg::K_HUND);
    assign sp_tens = m4sd_pkg::split_dec({7'd0, r_rem3}, m4sd_pkg::K_TEN);

    // Valid bits of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ld1) r_v1 <= i_s_tvalid;
            if (ld2) r_v2 <= r_v1;
            if (ld3) r_v3 <= r_v2;
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_cmd1    <= i_s_tuser;
            r_night1  <= i_s_tdata[14];
            r_rounds1 <= i_s_tdata[30:15];
            r_val1    <= clamped;
        end
        if (ld2) begin
            r_cmd2    <= r_cmd1;
            r_night2  <= r_night1;
            r_rounds2 <= r_rounds1;
            r_thou2   <= sp_thou.q;
            r_rem2    <= sp_thou.r[9:0];
        end
        if (ld3) begin
            r_cmd3    <= r_cmd2;
            r_night3  <= r_night2;
            r_rounds3 <= r_rounds2;
            r_thou3   <= r_thou2;
            r_hund3   <= sp_hund.q;
            r_rem3    <= sp_hund.r[6:0];
        end
    end

    // Last split and the first lit phase after leading zeros.
    always_comb begin
        o_q_entry.cmd    = r_cmd3;
        o_q_entry.thou   = r_thou3;
        o_q_entry.hund   = r_hund3;
        o_q_entry.tens   = sp_tens.q;
        o_q_entry.ones   = sp_tens.r[3:0];
        o_q_entry.night  = r_night3;
        o_q_entry.rounds = r_rounds3;
        priority if (r_thou3 != 4'd0) begin
            o_q_entry.first = m4sd_pkg::PH_THOU;
        end else if (r_hund3 != 4'd0) begin
            o_q_entry.first = m4sd_pkg::PH_HUND;
        end else if (sp_tens.q != 4'd0) begin
            o_q_entry.first = m4sd_pkg::PH_TENS;
        end else begin
            o_q_entry.first = m4sd_pkg::PH_ONES;
        end
    end

    assign o_q_valid = r_v3;

endmodule

// ===== rtl/m4sd_queue.sv =====
// ----------------------------------------------------------------------------
// m4sd_queue: entry queue between front and back
// A small register queue that lets the input stage and the scan engine
// stall independently.
// ----------------------------------------------------------------------------
module m4sd_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  m4sd_pkg::t_qent i_push_entry,
    output logic            o_pop_valid,
    input  logic            i_pop,
    output m4sd_pkg::t_qent o_pop_entry
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    m4sd_pkg::t_qent r_mem [DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_count;
    logic            push, pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;
    assign o_pop_entry  = r_mem[r_rd];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            if (pop)  r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            if (push && !pop) begin
                r_count <= r_count + CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= i_push_entry;
    end

endmodule

// ===== rtl/m4sd_back.sv =====
// ----------------------------------------------------------------------------
// m4sd_back: scan engine of the display driver
// Carries out show and tick transactions on the scan state and registers
// the segment and digit enable result of each one.
// ----------------------------------------------------------------------------
module m4sd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  m4sd_pkg::t_cfg  i_cfg,
    input  logic            i_q_valid,
    output logic            o_q_pop,
    input  m4sd_pkg::t_qent i_q_entry,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output logic [15:0]     o_m_tdata   // [7:0] segments, [11:8] digit_enable_n, [12] active
);

    // Scan state.
    logic [3:0]      r_digit [4];
    logic            r_night;
    logic [15:0]     r_rounds;
    logic [15:0]     r_ticks;
    m4sd_pkg::t_phase r_phase, r_first;

    logic [3:0]      n_digit [4];
    logic            n_night;
    logic [15:0]     n_rounds;
    logic [15:0]     n_ticks;
    m4sd_pkg::t_phase n_phase, n_first;

    // Output register.
    logic            r_out_valid;
    logic [15:0]     r_out_data;
    logic [15:0]     n_out_data;

    logic            take;
    logic [15:0]     len_raw, len;
    logic [16:0]     tick_inc;
    logic            phase_done;
    logic [15:0]     rounds_dec;
    logic [3:0]      shown;
    logic [3:0]      enables_n;
    logic [7:0]      seg_out;

    // Map a digit through the segment table and the pin permutation.
    function automatic logic [7:0] pattern_of(input logic [3:0] d, input m4sd_pkg::t_cfg c);
        logic [7:0] raw;
        logic [7:0] res;
        res = 8'd0;
        if (d < 4'd8) begin
            raw = c.seg_low[{d[2:0], 3'b000} +: 8];
        end else if (d == 4'd8) begin
            raw = c.seg_high[7:0];
        end else begin
            raw = c.seg_high[15:8];
        end
        for (int p = 0; p < 8; p++) begin
            for (int i = 0; i < 8; i++) begin
                if (raw[i] && (c.pin_map[3*i +: 3] == 3'(p))) res[p] = 1'b1;
            end
        end
        return res;
    endfunction

    // Take the next transaction when the output register is free or drains.
    assign take    = i_q_valid && (!r_out_valid || i_m_tready);
    assign o_q_pop = take;

    // Phase length; a zero length counts as one.
    assign len_raw    = (r_phase == m4sd_pkg::PH_NIGHT) ? i_cfg.night_ticks : i_cfg.digit_ticks;
    assign len        = (len_raw == 16'd0) ? 16'd1 : len_raw;
    assign tick_inc   = {1'b0, r_ticks} + 17'd1;
    assign phase_done = !(tick_inc < {1'b0, len});
    assign rounds_dec = r_rounds - 16'd1;

    // Next scan state.
    always_comb begin
        n_digit  = r_digit;
        n_night  = r_night;
        n_rounds = r_rounds;
        n_ticks  = r_ticks;
        n_phase  = r_phase;
        n_first  = r_first;
        if (i_q_entry.cmd) begin
            n_digit[0] = i_q_entry.thou;
            n_digit[1] = i_q_entry.hund;
            n_digit[2] = i_q_entry.tens;
            n_digit[3] = i_q_entry.ones;
            n_night    = i_q_entry.night;
            n_rounds   = i_q_entry.rounds;
            n_ticks    = 16'd0;
            n_first    = i_q_entry.first;
            n_phase    = (i_q_entry.rounds != 16'd0) ? i_q_entry.first : m4sd_pkg::PH_THOU;
        end else if (r_rounds != 16'd0) begin
            if (!phase_done) begin
                n_ticks = tick_inc[15:0];
            end else begin
                n_ticks = 16'd0;
                unique case (r_phase)
                    m4sd_pkg::PH_THOU: n_phase = m4sd_pkg::PH_HUND;
                    m4sd_pkg::PH_HUND: n_phase = m4sd_pkg::PH_TENS;
                    m4sd_pkg::PH_TENS: n_phase = m4sd_pkg::PH_ONES;
                    m4sd_pkg::PH_ONES: begin
                        if (r_night) begin
                            n_phase = m4sd_pkg::PH_NIGHT;
                        end else begin
                            n_rounds = rounds_dec;
                            n_phase  = (rounds_dec != 16'd0) ? r_first : m4sd_pkg::PH_THOU;
                        end
                    end
                    default: begin
                        // End of round after the night blank phase.
                        n_rounds = rounds_dec;
                        n_phase  = (rounds_dec != 16'd0) ? r_first : m4sd_pkg::PH_THOU;
                    end
                endcase
            end
        end
    end

    // Result for the state after this transaction.
    always_comb begin
        unique case (n_phase)
            m4sd_pkg::PH_THOU: shown = n_digit[0];
            m4sd_pkg::PH_HUND: shown = n_digit[1];
            m4sd_pkg::PH_TENS: shown = n_digit[2];
            default:           shown = n_digit[3];
        endcase
        enables_n = ~{n_phase[0], n_phase[1], n_phase[2], n_phase[3]};
        seg_out   = pattern_of(shown, i_cfg);
        if (n_rounds == 16'd0) begin
            n_out_data = {3'b000, 1'b0, 4'hF, 8'h00};
        end else begin
            n_out_data = {3'b000, 1'b1, enables_n, seg_out};
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) r_digit[k] <= 4'd0;
            r_night     <= 1'b0;
            r_rounds    <= 16'd0;
            r_ticks     <= 16'd0;
            r_phase     <= m4sd_pkg::PH_THOU;
            r_first     <= m4sd_pkg::PH_THOU;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_digit  <= n_digit;
                r_night  <= n_night;
                r_rounds <= n_rounds;
                r_ticks  <= n_ticks;
                r_phase  <= n_phase;
                r_first  <= n_first;
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (take) r_out_data <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // An idle scan sits at the start of a round with no ticks spent.
    a_idle_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rounds == 16'd0) |-> (r_phase == m4sd_pkg::PH_THOU && r_ticks == 16'd0))
        else $error("idle scan state not at round start");

    // The night blank phase is only reached with night mode on.
    a_night_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == m4sd_pkg::PH_NIGHT) |-> r_night)
        else $error("night phase without night mode");

    // An inactive result has all digits off and all segments dark.
    a_idle_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[12]) |-> (o_m_tdata[11:0] == 12'hF00))
        else $error("inactive result lights the display");

    // A show with rounds left makes the scan active at its first digit.
    a_show_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_q_entry.cmd && i_q_entry.rounds != 16'd0)
        |=> (r_phase == r_first && r_ticks == 16'd0 && o_m_tdata[12]))
        else $error("show did not restart the scan");

endmodule
